// ----- sv/mdu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mdu_pkg
// Shared codes, types and sizes of the multiply and divide unit.
// ----------------------------------------------------------------------------
package mdu_pkg;

    // Operation codes
    localparam logic [2:0] OP_MULU  = 3'd0;
    localparam logic [2:0] OP_MUL   = 3'd1;
    localparam logic [2:0] OP_MULUB = 3'd2;
    localparam logic [2:0] OP_MULB  = 3'd3;
    localparam logic [2:0] OP_DIVU  = 3'd4;
    localparam logic [2:0] OP_DIV   = 3'd5;
    localparam logic [2:0] OP_DIVUB = 3'd6;
    localparam logic [2:0] OP_DIVB  = 3'd7;

    // Divider arrangement: quotient bits resolved per stage, and stage count
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES      = 32 / STEPS_PER_STAGE;

    // Control travelling with each item
    typedef struct packed {
        logic valid;
        logic is_div;
        logic word;
        logic sgn;
        logic nneg;
        logic dneg;
        logic dbz;
    } t_ctl;

    // Data travelling with each item
    typedef struct packed {
        logic [15:0] rem;   // partial remainder
        logic [31:0] nq;    // dividend bits still to use, quotient bits shifted in
        logic [15:0] den;   // divisor magnitude
        logic [31:0] prod;  // multiply result
    } t_dat;

endpackage
`default_nettype wire

// ----- sv/md_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md_req_if
// Request channel: operation code and operands with valid/ready.
// ----------------------------------------------------------------------------
interface md_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] first_operand;
    logic [15:0] second_operand;

    modport source (output valid, req_type, first_operand, second_operand, input ready);
    modport sink   (input valid, req_type, first_operand, second_operand, output ready);
endinterface
`default_nettype wire

// ----- sv/md_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// md_rsp_if
// Result channel: result word and flags with valid/ready.
// ----------------------------------------------------------------------------
interface md_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_word;
    logic        divide_by_zero;
    logic        quotient_overflow;

    modport source (output valid, result_word, divide_by_zero, quotient_overflow,
                    input ready);
    modport sink   (input valid, result_word, divide_by_zero, quotient_overflow,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/mdu_div_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mdu_div_stage
// One registered stage of the restoring divider, a few quotient bits deep.
// ----------------------------------------------------------------------------
module mdu_div_stage (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  wire mdu_pkg::t_ctl i_ctl,
    input  wire mdu_pkg::t_dat i_dat,
    output mdu_pkg::t_ctl      o_ctl,
    output mdu_pkg::t_dat      o_dat
);

    mdu_pkg::t_ctl r_ctl;
    mdu_pkg::t_dat r_dat;
    mdu_pkg::t_dat n_dat;

    // Shift-and-subtract steps
    always_comb begin
        logic [16:0] tr;
        logic [16:0] diff;
        logic        ge;
        n_dat = i_dat;
        for (int k = 0; k < mdu_pkg::STEPS_PER_STAGE; k++) begin
            tr       = {n_dat.rem, n_dat.nq[31]};
            diff     = tr - {1'b0, n_dat.den};
            ge       = (tr >= {1'b0, n_dat.den});
            n_dat.nq = {n_dat.nq[30:0], ge};
            n_dat.rem = ge ? diff[15:0] : tr[15:0];
        end
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dat <= n_dat;
        end
    end

    assign o_ctl = r_ctl;
    assign o_dat = r_dat;

endmodule
`default_nettype wire

// ----- sv/mcu_multiply_divide_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcu_multiply_divide_unit
// Pipelined word/byte multiply and divide, signed and unsigned.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries the operation code and operands; an item is taken when
//   valid and ready are both high. o_rsp returns one item per request, in
//   order: the product, or quotient (low half) and remainder (high half),
//   with divide-by-zero and quotient-overflow flags.
// Pipeline: ten register stages: operand preparation (sign magnitudes),
//   eight divider stages of four quotient bits each (the multiply runs in
//   the first of them), and the output register behind the sign fix and
//   packing.
// Throughput: one item per cycle while the output is not stalled, the divider being fully pipelined.
// Reset: synchronous, active low; all stage valid bits clear, the pipe is
//   empty and ready is high.
// Stall: when the output holds an item the receiver has not taken, the
//   whole pipe freezes and i_req.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mcu_multiply_divide_unit (
    input  wire      i_clk,
    input  wire      i_rst_n,
    md_req_if.sink   i_req,
    md_rsp_if.source o_rsp
);

    logic en;

    // Prepared operands
    mdu_pkg::t_ctl       r_p_ctl;
    logic [31:0]         r_p_num;
    logic [15:0]         r_p_den;
    logic signed [16:0]  r_p_ma;
    logic signed [16:0]  r_p_mb;

    mdu_pkg::t_ctl n_p_ctl;
    logic [31:0]   n_p_num;
    logic [15:0]   n_p_den;
    logic [16:0]   n_p_ma;
    logic [16:0]   n_p_mb;

    // Divider chain
    mdu_pkg::t_ctl s_ctl [mdu_pkg::DIV_STAGES+1];
    mdu_pkg::t_dat s_dat [mdu_pkg::DIV_STAGES+1];

    // Output register
    logic        r_o_valid;
    logic [31:0] r_o_res;
    logic        r_o_dbz;
    logic        r_o_ovf;
    logic [31:0] n_o_res;
    logic        n_o_dbz;
    logic        n_o_ovf;

    logic signed [33:0] mprod;

    assign en          = !r_o_valid || o_rsp.ready;
    assign i_req.ready = en;

    // Operand preparation
    always_comb begin
        logic [2:0]  op;
        logic [31:0] a;
        logic [15:0] b;
        logic [31:0] num;
        logic [31:0] nneg32;
        logic [15:0] den;
        logic [15:0] dneg16;
        op = i_req.req_type;
        a  = i_req.first_operand;
        b  = i_req.second_operand;
        n_p_ctl.valid  = i_req.valid;
        n_p_ctl.is_div = op[2];
        n_p_ctl.word   = !op[1];
        n_p_ctl.sgn    = op[0];
        if (!op[1]) begin
            n_p_ma = {op[0] & a[15], a[15:0]};
            n_p_mb = {op[0] & b[15], b[15:0]};
            num    = a;
            den    = b;
            n_p_ctl.nneg = op[0] & a[31];
            n_p_ctl.dneg = op[0] & b[15];
        end else begin
            n_p_ma = {{9{op[0] & a[7]}}, a[7:0]};
            n_p_mb = {{9{op[0] & b[7]}}, b[7:0]};
            num    = {16'd0, a[15:0]};
            den    = {8'd0, b[7:0]};
            n_p_ctl.nneg = op[0] & a[15];
            n_p_ctl.dneg = op[0] & b[7];
        end
        n_p_ctl.dbz = op[2] && (den == 16'd0);
        nneg32 = 32'd0 - num;
        dneg16 = 16'd0 - den;
        if (n_p_ctl.nneg) begin
            n_p_num = op[1] ? {16'd0, nneg32[15:0]} : nneg32;
        end else begin
            n_p_num = num;
        end
        if (n_p_ctl.dneg) begin
            n_p_den = op[1] ? {8'd0, dneg16[7:0]} : dneg16;
        end else begin
            n_p_den = den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else if (en) begin
            r_p_ctl <= n_p_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_num <= n_p_num;
            r_p_den <= n_p_den;
            r_p_ma  <= signed'(n_p_ma);
            r_p_mb  <= signed'(n_p_mb);
        end
    end

    // Multiply alongside the first divider stage
    assign mprod = r_p_ma * r_p_mb;

    always_comb begin
        s_ctl[0]     = r_p_ctl;
        s_dat[0].rem = 16'd0;
        s_dat[0].nq  = r_p_num;
        s_dat[0].den = r_p_den;
        s_dat[0].prod = r_p_ctl.word ? mprod[31:0] : {16'd0, mprod[15:0]};
    end

    // Divider stages
    for (genvar g = 0; g < mdu_pkg::DIV_STAGES; g++) begin : g_div
        mdu_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (s_ctl[g]),
            .i_dat   (s_dat[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_dat   (s_dat[g+1])
        );
    end

    // Sign fix, overflow check and packing
    always_comb begin
        mdu_pkg::t_ctl c;
        logic [31:0] q;
        logic [15:0] r;
        logic [31:0] qf;
        logic [15:0] rf;
        logic [31:0] lim;
        logic        qneg;
        c    = s_ctl[mdu_pkg::DIV_STAGES];
        q    = s_dat[mdu_pkg::DIV_STAGES].nq;
        r    = s_dat[mdu_pkg::DIV_STAGES].rem;
        qneg = c.nneg ^ c.dneg;
        qf   = qneg ? (32'd0 - q) : q;
        rf   = c.nneg ? (16'd0 - r) : r;
        if (c.word) begin
            lim = !c.sgn ? 32'h0000_FFFF : (qneg ? 32'h0000_8000 : 32'h0000_7FFF);
        end else begin
            lim = !c.sgn ? 32'h0000_00FF : (qneg ? 32'h0000_0080 : 32'h0000_007F);
        end
        if (!c.is_div) begin
            n_o_res = s_dat[mdu_pkg::DIV_STAGES].prod;
            n_o_dbz = 1'b0;
            n_o_ovf = 1'b0;
        end else if (c.dbz) begin
            n_o_res = 32'd0;
            n_o_dbz = 1'b1;
            n_o_ovf = 1'b0;
        end else begin
            n_o_res = c.word ? {rf, qf[15:0]} : {16'd0, rf[7:0], qf[7:0]};
            n_o_dbz = 1'b0;
            n_o_ovf = (q > lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= s_ctl[mdu_pkg::DIV_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res <= n_o_res;
            r_o_dbz <= n_o_dbz;
            r_o_ovf <= n_o_ovf;
        end
    end

    assign o_rsp.valid             = r_o_valid;
    assign o_rsp.result_word       = r_o_res;
    assign o_rsp.divide_by_zero    = r_o_dbz;
    assign o_rsp.quotient_overflow = r_o_ovf;

endmodule
`default_nettype wire

// ----- bench/tb_mcu_multiply_divide_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mcu_multiply_divide_unit
// Drives word and byte multiplies and divides, signed and unsigned, through
// the request channel with random gaps and result stalls, predicts every
// product, quotient/remainder pair and flag, and checks results in order.
// ----------------------------------------------------------------------------
module tb_mcu_multiply_divide_unit;

    typedef struct packed {
        logic [31:0] word;
        logic        dbz;
        logic        ovf;
    } t_md_result;

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt;
    int   mismatch_cnt;
    int   result_cnt;
    bit   finished;

    t_md_result md_expected_q[$];

    md_req_if req_if ();
    md_rsp_if rsp_if ();

    mcu_multiply_divide_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT && !finished) begin
            $display("tb_mcu_multiply_divide_unit NOT OK");
            $finish;
        end
    end

    // Unsigned divide of a 2w-bit dividend by a w-bit divisor
    function automatic t_md_result udiv_predict(logic [31:0] num, logic [15:0] den, int w);
        t_md_result r;
        logic [31:0] q;
        logic [31:0] rm;
        logic [31:0] msk;
        msk = (32'd1 << w) - 1;
        q   = num / {16'd0, den};
        rm  = num % {16'd0, den};
        r.dbz  = 1'b0;
        r.ovf  = (q > msk);
        r.word = (q & msk) | ((rm & msk) << w);
        return r;
    endfunction

    // Signed divide: truncate toward zero, remainder follows dividend sign
    function automatic t_md_result sdiv_predict(logic [31:0] num, logic [15:0] den, int w);
        t_md_result r;
        logic [31:0] msk;
        logic [31:0] msk2;
        logic [31:0] na;
        logic [31:0] da;
        logic [31:0] q;
        logic [31:0] rm;
        logic [31:0] half;
        logic        nneg;
        logic        dneg;
        msk  = (32'd1 << w) - 1;
        msk2 = (w == 16) ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        nneg = num[2*w-1];
        dneg = den[w-1];
        na   = nneg ? ((-num) & msk2) : num;
        da   = dneg ? ((-{16'd0, den}) & msk) : {16'd0, den};
        q    = na / da;
        rm   = na % da;
        half = 32'd1 << (w - 1);
        r.dbz = 1'b0;
        r.ovf = (nneg != dneg) ? (q > half) : (q > half - 1);
        if (nneg != dneg) q = -q;
        if (nneg) rm = -rm;
        r.word = (q & msk) | ((rm & msk) << w);
        return r;
    endfunction

    function automatic t_md_result md_predict(logic [2:0] op, logic [31:0] a, logic [15:0] b);
        t_md_result r;
        logic [15:0] den;
        logic [31:0] sa;
        logic [31:0] sb;
        r = '0;
        case (op)
            mdu_pkg::OP_MULU: begin
                r.word = {16'd0, a[15:0]} * {16'd0, b};
            end
            mdu_pkg::OP_MUL: begin
                sa     = {{16{a[15]}}, a[15:0]};
                sb     = {{16{b[15]}}, b};
                r.word = sa * sb;
            end
            mdu_pkg::OP_MULUB: begin
                r.word = {16'd0, {8'd0, a[7:0]} * {8'd0, b[7:0]}};
            end
            mdu_pkg::OP_MULB: begin
                sa     = {{24{a[7]}}, a[7:0]};
                sb     = {{24{b[7]}}, b[7:0]};
                r.word = (sa * sb) & 32'h0000_FFFF;
            end
            default: begin
                den = (op == mdu_pkg::OP_DIVU || op == mdu_pkg::OP_DIV) ? b : {8'd0, b[7:0]};
                if (den == 16'd0) begin
                    r.dbz = 1'b1;
                end else begin
                    case (op)
                        mdu_pkg::OP_DIVU:  r = udiv_predict(a, den, 16);
                        mdu_pkg::OP_DIV:   r = sdiv_predict(a, den, 16);
                        mdu_pkg::OP_DIVUB: r = udiv_predict({16'd0, a[15:0]}, den, 8);
                        default:           r = sdiv_predict({16'd0, a[15:0]}, den, 8);
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle_cnt);
        mismatch_cnt++;
    endtask

    // Result side: random stalls, in-order compare
    initial begin
        t_md_result e;
        int stall;
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 7) == 0) stall = 0;
            repeat (stall) begin
                rsp_if.ready <= 1'b0;
                @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
            // item taken at this edge
            result_cnt++;
            if (md_expected_q.size() == 0) begin
                report_mismatch("unexpected result", rsp_if.result_word, 32'd0);
            end else begin
                e = md_expected_q.pop_front();
                if (rsp_if.result_word !== e.word)
                    report_mismatch("result_word", rsp_if.result_word, e.word);
                if (rsp_if.divide_by_zero !== e.dbz)
                    report_mismatch("divide_by_zero", rsp_if.divide_by_zero, e.dbz);
                if (rsp_if.quotient_overflow !== e.ovf)
                    report_mismatch("quotient_overflow", rsp_if.quotient_overflow, e.ovf);
            end
        end
    end

    // Send one item after a random gap; predict it on acceptance
    task automatic send_request(logic [2:0] op, logic [31:0] a, logic [15:0] b);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.req_type       <= op;
        req_if.first_operand  <= a;
        req_if.second_operand <= b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        md_expected_q.push_back(md_predict(op, a, b));
    endtask

    task automatic drain_results();
        while (md_expected_q.size() != 0) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        logic [2:0] op;
        for (int k = 0; k < 8; k++) begin
            op = 3'(k);
            send_request(op, 32'hFFFF_FFFF, 16'hFFFF);
            send_request(op, 32'h8000_0000, 16'h8000);
        end
        // zero divisor, word and byte
        send_request(mdu_pkg::OP_DIVU, 32'h1234_5678, 16'h0000);
        send_request(mdu_pkg::OP_DIVB, 32'h0000_1234, 16'hFF00);
        // most negative dividend by minus one
        send_request(mdu_pkg::OP_DIV, 32'h8000_0000, 16'hFFFF);
        send_request(mdu_pkg::OP_DIVB, 32'h0000_8000, 16'h00FF);
        // quotient too wide
        send_request(mdu_pkg::OP_DIVU, 32'hFFFF_0000, 16'h0001);
        send_request(mdu_pkg::OP_DIVUB, 32'h0000_FF00, 16'h0002);
        // signed truncation, negative remainder in the word case
        send_request(mdu_pkg::OP_DIV, 32'hFFFF_FFF9, 16'h0002);
        send_request(mdu_pkg::OP_DIVB, 32'h0000_0007, 16'h00FE);
        send_request(mdu_pkg::OP_MUL, 32'h0000_0000, 16'h0000);
    endtask

    task automatic test_pause_until_empty();
        send_request(mdu_pkg::OP_DIV, $urandom, 16'($urandom));
        send_request(mdu_pkg::OP_MULB, $urandom, 16'($urandom));
        drain_results();
        send_request(mdu_pkg::OP_DIVUB, $urandom, 16'($urandom_range(1, 255)));
    endtask

    task automatic test_random(int n);
        logic [2:0]  op;
        logic [31:0] a;
        logic [15:0] b;
        for (int k = 0; k < n; k++) begin
            op = 3'($urandom_range(0, 7));
            a  = $urandom;
            b  = 16'($urandom);
            // bias toward small divisors, quotients at the overflow boundary and small dividends
            case ($urandom_range(0, 5))
                0: b = 16'($urandom_range(0, 3));
                1: a = (op == mdu_pkg::OP_DIVU || op == mdu_pkg::OP_DIV)
                       ? {b ^ 16'($urandom_range(0, 1) << 15), a[15:0]} : a;
                2: a[31:8] = {24{a[7]}};
                default: ;
            endcase
            send_request(op, a, b);
            // now and then let the pipe run empty
            if ($urandom_range(0, 49) == 0) drain_results();
        end
    endtask

    initial begin
        cycle_cnt    = 0;
        mismatch_cnt = 0;
        result_cnt   = 0;
        finished     = 1'b0;
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.req_type       = mdu_pkg::OP_MULU;
        req_if.first_operand  = '0;
        req_if.second_operand = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pause_until_empty();
        test_random(1400);

        drain_results();
        repeat (30) @(posedge i_clk);
        finished = 1'b1;
        if (mismatch_cnt == 0 && md_expected_q.size() == 0) begin
            $display("tb_mcu_multiply_divide_unit OK");
        end else begin
            $display("tb_mcu_multiply_divide_unit NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
